FILE: rtl/assert_macros.svh
// assertion macros shared by the priority queue rtl
// expects clk and rst_n in the scope of the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequence that must hold in the cycle after a trigger
`define SPQ_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
// shared types and constants of the sorted priority queue
// no dependencies
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY     = 16;
    localparam int PRIO_BITS    = 16;
    localparam int PAYLOAD_BITS = 32;

    // operation codes on the request channel
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctrl_t;

endpackage

FILE: rtl/spq_if.sv
// request and response channel interfaces of the sorted priority queue
// depends on spq_pkg
`timescale 1ns / 1ps

interface spq_req_if #(
    parameter int PRIO_BITS    = spq_pkg::PRIO_BITS,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS
);
    logic                    valid;
    logic                    ready;
    logic                    op;
    logic [PRIO_BITS-1:0]    prio_in;
    logic [PAYLOAD_BITS-1:0] payload_in;

    modport source (output valid, op, prio_in, payload_in, input ready);
    modport sink   (input valid, op, prio_in, payload_in, output ready);
endinterface

interface spq_rsp_if #(
    parameter int PRIO_BITS    = spq_pkg::PRIO_BITS,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS,
    parameter int COUNT_BITS   = $clog2(spq_pkg::CAPACITY + 1)
);
    logic                    valid;
    logic                    ready;
    spq_pkg::status_t        status;
    logic [PRIO_BITS-1:0]    prio_out;
    logic [PAYLOAD_BITS-1:0] payload_out;
    logic [COUNT_BITS-1:0]   occupancy;

    modport source (output valid, status, prio_out, payload_out, occupancy, input ready);
    modport sink   (input valid, status, prio_out, payload_out, occupancy, output ready);
endinterface

FILE: rtl/spq_cell.sv
// one slot of the sorted array: holds an entry, compares it with the new priority
// and takes its own, the new, the left or the right entry; depends on spq_pkg
`timescale 1ns / 1ps

module spq_cell #(
    parameter int PRIO_BITS    = spq_pkg::PRIO_BITS,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS
) (
    input  logic                    clk,
    input  spq_pkg::cell_ctrl_t     ctrl,
    input  logic                    occupied,
    input  logic [PRIO_BITS-1:0]    new_prio,
    input  logic [PAYLOAD_BITS-1:0] new_payload,
    input  logic                    left_keep,
    input  logic [PRIO_BITS-1:0]    left_prio,
    input  logic [PAYLOAD_BITS-1:0] left_payload,
    input  logic [PRIO_BITS-1:0]    right_prio,
    input  logic [PAYLOAD_BITS-1:0] right_payload,
    output logic [PRIO_BITS-1:0]    prio,
    output logic [PAYLOAD_BITS-1:0] payload,
    output logic                    keep
);
    import spq_pkg::*;

    logic [PRIO_BITS-1:0]    prio_reg,    prio_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;

    // equal priorities stay ahead of the newcomer
    assign keep = occupied && (prio_reg >= new_prio);

    always_comb
    begin
        prio_next    = prio_reg;
        payload_next = payload_reg;
        if (ctrl.ins)
        begin
            if (keep)
            begin
                prio_next    = prio_reg;
                payload_next = payload_reg;
            end
            else if (left_keep)
            begin
                prio_next    = new_prio;
                payload_next = new_payload;
            end
            else
            begin
                prio_next    = left_prio;
                payload_next = left_payload;
            end
        end
        else if (ctrl.pop)
        begin
            prio_next    = right_prio;
            payload_next = right_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
    end

    assign prio    = prio_reg;
    assign payload = payload_reg;

endmodule

FILE: rtl/sorted_priority_queue_unit.sv
// Sorted priority queue built as a row of compare-and-shift cells.
// Request channel req: op selects insert or pop; an insert carries prio_in and
// payload_in. Response channel rsp: exactly one response per request, in order,
// with status, the popped prio_out/payload_out (zero unless a pop succeeded)
// and occupancy after the request.
// Every cell compares its entry with the new priority in parallel, so an insert
// or a pop completes in the cycle it is accepted; the response register is loaded
// in that same cycle. One request per cycle is sustained while the receiver keeps
// rsp.ready high, set by the single compare in each cell and the neighbor shift.
// Equal priorities leave in arrival order. An insert into a full queue is
// dropped with status full; a pop on an empty queue reports status empty.
// Reset empties the queue and the response register; the entry storage is not
// cleared, only slots below the entry count are ever read.
// While the receiver holds rsp.ready low, one response waits in the register
// and req.ready falls, so nothing is lost or repeated.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_priority_queue_unit #(
    parameter int CAPACITY     = spq_pkg::CAPACITY,
    parameter int PRIO_BITS    = spq_pkg::PRIO_BITS,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS
) (
    input logic       clk,
    input logic       rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    rsp_valid_reg;
    status_t                 status_reg, status_next;
    logic [PRIO_BITS-1:0]    prio_out_reg, prio_out_next;
    logic [PAYLOAD_BITS-1:0] payload_out_reg, payload_out_next;
    logic [CNT_W-1:0]        occ_reg;

    logic [PRIO_BITS-1:0]    prio_q    [CAPACITY];
    logic [PAYLOAD_BITS-1:0] payload_q [CAPACITY];
    logic [CAPACITY-1:0]     keep_q;

    logic       in_fire;
    logic       is_pop;
    logic       full;
    logic       empty;
    cell_ctrl_t ctrl;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign in_fire   = req.valid && req.ready;
    assign is_pop    = (req.op == OP_POP);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    assign ctrl.ins = in_fire && !is_pop && !full;
    assign ctrl.pop = in_fire && is_pop && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                    l_keep;
            logic [PRIO_BITS-1:0]    l_prio;
            logic [PAYLOAD_BITS-1:0] l_payload;
            logic [PRIO_BITS-1:0]    r_prio;
            logic [PAYLOAD_BITS-1:0] r_payload;

            if (gi == 0)
            begin : g_head
                // nothing ranks ahead of the head slot
                assign l_keep    = 1'b1;
                assign l_prio    = req.prio_in;
                assign l_payload = req.payload_in;
            end
            else
            begin : g_body
                assign l_keep    = keep_q[gi-1];
                assign l_prio    = prio_q[gi-1];
                assign l_payload = payload_q[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign r_prio    = prio_q[gi];
                assign r_payload = payload_q[gi];
            end
            else
            begin : g_mid
                assign r_prio    = prio_q[gi+1];
                assign r_payload = payload_q[gi+1];
            end

            spq_cell #(
                .PRIO_BITS    (PRIO_BITS),
                .PAYLOAD_BITS (PAYLOAD_BITS)
            ) u_cell (
                .clk           (clk),
                .ctrl          (ctrl),
                .occupied      (count_reg > CNT_W'(gi)),
                .new_prio      (req.prio_in),
                .new_payload   (req.payload_in),
                .left_keep     (l_keep),
                .left_prio     (l_prio),
                .left_payload  (l_payload),
                .right_prio    (r_prio),
                .right_payload (r_payload),
                .prio          (prio_q[gi]),
                .payload       (payload_q[gi]),
                .keep          (keep_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next       = count_reg;
        status_next      = ST_OK;
        prio_out_next    = '0;
        payload_out_next = '0;
        if (ctrl.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next       = count_reg - CNT_W'(1);
            prio_out_next    = prio_q[0];
            payload_out_next = payload_q[0];
        end
        else if (is_pop)
        begin
            status_next = ST_EMPTY;
        end
        else
        begin
            status_next = ST_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg      <= status_next;
            prio_out_reg    <= prio_out_next;
            payload_out_reg <= payload_out_next;
            occ_reg         <= count_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.prio_out    = prio_out_reg;
    assign rsp.payload_out = payload_out_reg;
    assign rsp.occupancy   = occ_reg;

    `SPQ_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `SPQ_ASSERT_NEXT(a_rsp_follows, in_fire, rsp_valid_reg, "no response after transaction")
    `SPQ_ASSERT_NEXT(a_pop_count, ctrl.pop, count_reg == $past(count_reg) - CNT_W'(1), "pop miscounted")
    `SPQ_ASSERT(a_head_sorted, (count_reg < CNT_W'(2)) || (prio_q[0] >= prio_q[1]), "head out of order")

endmodule

FILE: test/sorted_queue_monitor.sv
// response monitor for the sorted priority queue: keeps its own copy of the
// queue contents, predicts every response and compares it field by field
// depends on spq_pkg and the channel interfaces of spq_if.sv
`timescale 1ns / 1ps

module sorted_queue_monitor (
    input  logic clk,
    input  logic rst_n,
    spq_req_if   req,
    spq_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding
);

    localparam int SLOTS      = spq_pkg::CAPACITY;
    localparam int PW         = spq_pkg::PRIO_BITS;
    localparam int DW         = spq_pkg::PAYLOAD_BITS;
    localparam int COUNT_BITS = $clog2(spq_pkg::CAPACITY + 1);
    localparam int PRINT_CAP  = 100;

    typedef struct {
        spq_pkg::status_t      status;
        logic [PW-1:0]         prio;
        logic [DW-1:0]         payload;
        logic [COUNT_BITS-1:0] occupancy;
    } reply_t;

    // queue contents, slot 0 is served next
    logic [PW-1:0] held_prio    [SLOTS];
    logic [DW-1:0] held_payload [SLOTS];
    int            held_count;

    reply_t awaited_replies[$];
    reply_t want;

    initial begin
        mismatches  = 0;
        outstanding = 0;
        held_count  = 0;
    end

    task automatic note_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("%0t ns mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // applies one request to the held queue and returns the response it causes
    function automatic reply_t serve_request(input logic op, input logic [PW-1:0] prio,
                                             input logic [DW-1:0] payload);
        reply_t r;
        int     pos;
        int     i;
        r.status  = spq_pkg::ST_OK;
        r.prio    = '0;
        r.payload = '0;
        if (op == spq_pkg::OP_INSERT) begin
            if (held_count >= SLOTS) begin
                r.status = spq_pkg::ST_FULL;
            end
            else begin
                // new entry goes behind every entry of equal or higher priority
                pos = 0;
                while (pos < held_count && held_prio[pos] >= prio)
                    pos++;
                for (i = held_count; i > pos; i--)
                begin
                    held_prio[i]    = held_prio[i-1];
                    held_payload[i] = held_payload[i-1];
                end
                held_prio[pos]    = prio;
                held_payload[pos] = payload;
                held_count++;
            end
        end
        else begin
            if (held_count == 0) begin
                r.status = spq_pkg::ST_EMPTY;
            end
            else begin
                r.prio    = held_prio[0];
                r.payload = held_payload[0];
                for (i = 1; i < held_count; i++)
                begin
                    held_prio[i-1]    = held_prio[i];
                    held_payload[i-1] = held_payload[i];
                end
                held_count--;
            end
        end
        r.occupancy = COUNT_BITS'(held_count);
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n) begin
            held_count = 0;
            awaited_replies.delete();
        end
        else begin
            // a response always belongs to a request accepted at an earlier edge
            if (rsp.valid && rsp.ready) begin
                if (awaited_replies.size() == 0) begin
                    note_mismatch($sformatf("response with no request waiting, status %0d",
                                            rsp.status));
                end
                else begin
                    want = awaited_replies.pop_front();
                    if (rsp.status !== want.status)
                        note_mismatch($sformatf("status %0d, expected %0d",
                                                rsp.status, want.status));
                    if (rsp.prio_out !== want.prio)
                        note_mismatch($sformatf("prio_out %h, expected %h",
                                                rsp.prio_out, want.prio));
                    if (rsp.payload_out !== want.payload)
                        note_mismatch($sformatf("payload_out %h, expected %h",
                                                rsp.payload_out, want.payload));
                    if (rsp.occupancy !== want.occupancy)
                        note_mismatch($sformatf("occupancy %0d, expected %0d",
                                                rsp.occupancy, want.occupancy));
                end
            end
            if (req.valid && req.ready)
                awaited_replies.push_back(serve_request(req.op, req.prio_in, req.payload_in));
        end
        outstanding = awaited_replies.size();
    end

endmodule

FILE: test/sorted_priority_queue_unit_test.sv
// top of the sorted priority queue testbench: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict
// depends on spq_pkg, spq_if.sv, the block and sorted_queue_monitor
`timescale 1ns / 1ps

module sorted_priority_queue_unit_test;

    localparam int PW          = spq_pkg::PRIO_BITS;
    localparam int DW          = spq_pkg::PAYLOAD_BITS;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 350;

    logic clk;
    logic rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   mismatches;
    int   outstanding;
    int   quiet_cycles = 0;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    sorted_priority_queue_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sorted_queue_monitor monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
        rsp_ch.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);

    // ends the run when no transaction moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // mostly small ranges so that equal priorities are common
    function automatic logic [PW-1:0] pick_priority();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return PW'($urandom_range(7));
            5, 6:    return PW'($urandom_range(255));
            default: return PW'($urandom);
        endcase
    endfunction

    function automatic logic [DW-1:0] pick_payload();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return DW'($urandom);
        endcase
    endfunction

    task automatic send_request(input logic op, input logic [PW-1:0] prio,
                                input logic [DW-1:0] payload);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.prio_in    <= prio;
        req_ch.payload_in <= payload;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // stretches lean toward inserts or pops so the queue hits full and empty often
    task automatic run_random(input int n_items);
        int insert_pct;
        int k;
        insert_pct = 50;
        for (k = 0; k < n_items; k++)
        begin
            if (k % 40 == 0) begin
                case ($urandom_range(2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            end
            if ($urandom_range(99) < insert_pct)
                send_request(spq_pkg::OP_INSERT, pick_priority(), pick_payload());
            else
                send_request(spq_pkg::OP_POP, PW'($urandom), DW'($urandom));
        end
    endtask

    initial begin
        int k;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.op         = spq_pkg::OP_INSERT;
        req_ch.prio_in    = '0;
        req_ch.payload_in = '0;
        rsp_ch.ready      = 1'b0;
        tx_idle_pct       = 34;
        rx_idle_pct       = 55;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // pop on empty, fill past capacity with ties and extremes, then drain a few
        send_request(spq_pkg::OP_POP, '1, '1);
        for (k = 0; k < 17; k++)
        begin
            if (k == 0)
                send_request(spq_pkg::OP_INSERT, '1, '0);
            else if (k == 1)
                send_request(spq_pkg::OP_INSERT, '0, '1);
            else if (k < 6)
                send_request(spq_pkg::OP_INSERT, PW'(16'h8000), DW'(32'hA5A5_0000 + k));
            else
                send_request(spq_pkg::OP_INSERT, PW'(k * 16'h0101), DW'(32'h5A5A_0000 + k));
        end
        repeat (5) send_request(spq_pkg::OP_POP, '0, '0);

        run_random(PHASE_ITEMS);
        tx_idle_pct = 55;
        rx_idle_pct = 34;
        run_random(PHASE_ITEMS);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(PHASE_ITEMS);

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
